@@ sv/ond_pkg.sv @@
// ----------------------------------------------------------------------------
// ond_pkg
// Shared constants for the octahedral normal decoder.
// ----------------------------------------------------------------------------
package ond_pkg;

  // Full-scale code of one 16-bit unsigned-normalized coordinate
  localparam int unsigned ENC_MAX = 65535;

  // Signed width that holds 2*v - ENC_MAX and its folded forms
  localparam int unsigned COORD_W = 18;

  // Magnitude of one numerator, its square, and the sum of three squares
  localparam int unsigned MAG_W = 16;
  localparam int unsigned SQ_W  = 32;
  localparam int unsigned SUM_W = 34;

  // Lanes: x, y, z
  localparam int unsigned LANES = 3;

endpackage

@@ sv/ond_in_if.sv @@
// ----------------------------------------------------------------------------
// ond_in_if
// Request channel carrying one packed octahedral normal.
// ----------------------------------------------------------------------------
interface ond_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_normal;

  modport source (output valid, output packed_normal, input ready);
  modport sink   (input valid, input packed_normal, output ready);
endinterface

@@ sv/ond_out_if.sv @@
// ----------------------------------------------------------------------------
// ond_out_if
// Request channel carrying one decoded unit normal.
// ----------------------------------------------------------------------------
interface ond_out_if #(parameter int unsigned W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] norm_x;
  logic signed [W-1:0] norm_y;
  logic signed [W-1:0] norm_z;

  modport source (output valid, output norm_x, output norm_y, output norm_z, input ready);
  modport sink   (input valid, input norm_x, input norm_y, input norm_z, output ready);
endinterface

@@ sv/octahedral_normal_decode.sv @@
// ----------------------------------------------------------------------------
// octahedral_normal_decode
// Octahedral unorm16x2 normal to unit vector, exactly rounded fixed point.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_i    | in  | packed_normal[31:0]  (x code low half, y code high half)
// out_o   | out | norm_x, norm_y, norm_z, signed, OUT_FRAC_BITS fraction bits
//
// One request enters per cycle unless the output stalls; the path is three prep
// stages, one stage per result bit, and one output register.
// The per-bit stage chain sets the depth; all stages move together.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module octahedral_normal_decode #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  ond_in_if.sink                   in_i,
  ond_out_if.source                out_o
);

  localparam int unsigned F  = OUT_FRAC_BITS;
  localparam int unsigned W  = 2 * F + 39;
  localparam int unsigned OW = F + 2;
  localparam int unsigned NS = F + 1;

  logic en;
  logic out_valid_q;

  // Move every stage when the output slot is free or being drained
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  logic                        c_valid [NS+1];
  logic [ond_pkg::LANES-1:0]   c_neg   [NS+1];
  logic [ond_pkg::SQ_W-1:0]    c_m2    [NS+1][ond_pkg::LANES];
  logic [ond_pkg::SUM_W-1:0]   c_sq    [NS+1];
  logic signed [W-1:0]         c_s     [NS+1][ond_pkg::LANES];
  logic signed [W-1:0]         c_u     [NS+1][ond_pkg::LANES];
  logic [F:0]                  c_q     [NS+1][ond_pkg::LANES];

  ond_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .packed_i (in_i.packed_normal),
    .valid_o  (c_valid[0]),
    .neg_o    (c_neg[0]),
    .m2_o     (c_m2[0]),
    .sq_o     (c_sq[0])
  );

  // Seed q = 0, so 2q-1 = -1: S = sq, U = -sq
  always_comb begin
    for (int k = 0; k < ond_pkg::LANES; k++) begin
      c_s[0][k] = $signed(W'(c_sq[0]));
      c_u[0][k] = -$signed(W'(c_sq[0]));
      c_q[0][k] = '0;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    ond_step #(.F(F), .BIT(F - j)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c_valid[j]),
      .neg_i   (c_neg[j]),
      .m2_i    (c_m2[j]),
      .sq_i    (c_sq[j]),
      .s_i     (c_s[j]),
      .u_i     (c_u[j]),
      .q_i     (c_q[j]),
      .valid_o (c_valid[j+1]),
      .neg_o   (c_neg[j+1]),
      .m2_o    (c_m2[j+1]),
      .sq_o    (c_sq[j+1]),
      .s_o     (c_s[j+1]),
      .u_o     (c_u[j+1]),
      .q_o     (c_q[j+1])
    );
  end

  logic signed [OW-1:0] res_d [ond_pkg::LANES];
  logic signed [OW-1:0] res_q [ond_pkg::LANES];

  // Apply the signs
  always_comb begin
    for (int k = 0; k < ond_pkg::LANES; k++) begin
      res_d[k] = c_neg[NS][k] ? -$signed({1'b0, c_q[NS][k]}) : $signed({1'b0, c_q[NS][k]});
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_valid[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.norm_x = res_q[0];
  assign out_o.norm_y = res_q[1];
  assign out_o.norm_z = res_q[2];

endmodule

@@ sv/ond_prep.sv @@
// ----------------------------------------------------------------------------
// ond_prep
// Unpack, fold and square the numerators; three register stages.
// ----------------------------------------------------------------------------
module ond_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [31:0]                 packed_i,
  output logic                        valid_o,
  output logic [ond_pkg::LANES-1:0]   neg_o,
  output logic [ond_pkg::SQ_W-1:0]    m2_o [ond_pkg::LANES],
  output logic [ond_pkg::SUM_W-1:0]   sq_o
);

  localparam int unsigned CW = ond_pkg::COORD_W;
  localparam logic signed [CW-1:0] ENC = CW'(ond_pkg::ENC_MAX);

  logic signed [CW-1:0] ax, ay, abx, aby, nz, fx, fy, mx, my, mz;

  // Map codes to odd numerators and fold the lower hemisphere
  always_comb begin
    ax  = $signed({1'b0, packed_i[15:0], 1'b0}) - ENC;
    ay  = $signed({1'b0, packed_i[31:16], 1'b0}) - ENC;
    abx = ax[CW-1] ? -ax : ax;
    aby = ay[CW-1] ? -ay : ay;
    nz  = ENC - abx - aby;
    fx  = ENC - aby;
    fy  = ENC - abx;
    mx  = nz[CW-1] ? fx : abx;
    my  = nz[CW-1] ? fy : aby;
    mz  = nz[CW-1] ? -nz : nz;
  end

  logic                                a_valid_q, b_valid_q, c_valid_q;
  logic [ond_pkg::LANES-1:0]           a_neg_q, b_neg_q, c_neg_q;
  logic [ond_pkg::MAG_W-1:0]           a_mag_q [ond_pkg::LANES];
  logic [ond_pkg::SQ_W-1:0]            b_m2_q  [ond_pkg::LANES];
  logic [ond_pkg::SQ_W-1:0]            c_m2_q  [ond_pkg::LANES];
  logic [ond_pkg::SUM_W-1:0]           c_sq_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Stage A: magnitudes; stage B: squares; stage C: sum of squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_neg_q    <= {nz[CW-1], ay[CW-1], ax[CW-1]};
      a_mag_q[0] <= mx[ond_pkg::MAG_W-1:0];
      a_mag_q[1] <= my[ond_pkg::MAG_W-1:0];
      a_mag_q[2] <= mz[ond_pkg::MAG_W-1:0];
      b_neg_q    <= a_neg_q;
      for (int k = 0; k < ond_pkg::LANES; k++) begin
        b_m2_q[k] <= a_mag_q[k] * a_mag_q[k];
        c_m2_q[k] <= b_m2_q[k];
      end
      c_neg_q <= b_neg_q;
      c_sq_q  <= ond_pkg::SUM_W'(b_m2_q[0]) + ond_pkg::SUM_W'(b_m2_q[1])
               + ond_pkg::SUM_W'(b_m2_q[2]);
    end
  end

  assign valid_o = c_valid_q;
  assign neg_o   = c_neg_q;
  assign m2_o    = c_m2_q;
  assign sq_o    = c_sq_q;

endmodule

@@ sv/ond_step.sv @@
// ----------------------------------------------------------------------------
// ond_step
// One result bit of the rounded reciprocal-root scaling, for all three lanes.
// Tracks S = (2q-1)^2 * sq and U = (2q-1) * sq so each trial is shifts and adds.
// ----------------------------------------------------------------------------
module ond_step #(
  parameter int unsigned F   = 14,
  parameter int unsigned BIT = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ond_pkg::LANES-1:0]     neg_i,
  input  logic [ond_pkg::SQ_W-1:0]      m2_i [ond_pkg::LANES],
  input  logic [ond_pkg::SUM_W-1:0]     sq_i,
  input  logic signed [2*F+38:0]        s_i  [ond_pkg::LANES],
  input  logic signed [2*F+38:0]        u_i  [ond_pkg::LANES],
  input  logic [F:0]                    q_i  [ond_pkg::LANES],
  output logic                          valid_o,
  output logic [ond_pkg::LANES-1:0]     neg_o,
  output logic [ond_pkg::SQ_W-1:0]      m2_o [ond_pkg::LANES],
  output logic [ond_pkg::SUM_W-1:0]     sq_o,
  output logic signed [2*F+38:0]        s_o  [ond_pkg::LANES],
  output logic signed [2*F+38:0]        u_o  [ond_pkg::LANES],
  output logic [F:0]                    q_o  [ond_pkg::LANES]
);

  localparam int unsigned W  = 2 * F + 39;
  localparam int unsigned QW = F + 1;
  localparam logic [QW-1:0] LOW_MASK = QW'((1 << BIT) - 1);
  localparam logic [QW-1:0] ONE      = QW'(1) << F;

  logic signed [W-1:0] sq_w;
  logic signed [W-1:0] cand [ond_pkg::LANES];
  logic signed [W-1:0] thr  [ond_pkg::LANES];
  logic signed [W-1:0] s_d  [ond_pkg::LANES];
  logic signed [W-1:0] u_d  [ond_pkg::LANES];
  logic [QW-1:0]       q_d  [ond_pkg::LANES];
  logic                take [ond_pkg::LANES];

  // Trial-set this bit; keep it when the rounding bound still holds
  always_comb begin
    sq_w = $signed(W'(sq_i));
    for (int k = 0; k < ond_pkg::LANES; k++) begin
      thr[k]  = $signed(W'({m2_i[k], {(2 * F + 2){1'b0}}}));
      cand[k] = s_i[k] + (u_i[k] <<< (BIT + 2)) + (sq_w <<< (2 * BIT + 2));
      take[k] = !q_i[k][F] && (cand[k] <= thr[k]);
      s_d[k]  = take[k] ? cand[k] : s_i[k];
      u_d[k]  = take[k] ? u_i[k] + (sq_w <<< (BIT + 1)) : u_i[k];
      q_d[k]  = q_i[k] | (QW'(take[k]) << BIT);
    end
  end

  // Hold the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // Advance the lane data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_o <= neg_i;
      m2_o  <= m2_i;
      sq_o  <= sq_i;
      s_o   <= s_d;
      u_o   <= u_d;
      q_o   <= q_d;
    end
  end

`ifndef SYNTHESIS
  // Bits below this stage stay clear
  a_low_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (((q_o[0] | q_o[1] | q_o[2]) & LOW_MASK) == '0))
    else $error("low result bits set early");

  // Magnitude never passes one
  a_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((!q_o[0][F] || (q_o[0] & ~ONE) == '0)
              && (!q_o[1][F] || (q_o[1] & ~ONE) == '0)
              && (!q_o[2][F] || (q_o[2] & ~ONE) == '0)))
    else $error("magnitude above one");

  // Accumulated square stays within the bound once a bit has been kept
  a_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((q_o[0] == '0
                  || s_o[0] <= $signed(W'({m2_o[0], {(2 * F + 2){1'b0}}})))
              && (q_o[1] == '0
                  || s_o[1] <= $signed(W'({m2_o[1], {(2 * F + 2){1'b0}}})))
              && (q_o[2] == '0
                  || s_o[2] <= $signed(W'({m2_o[2], {(2 * F + 2){1'b0}}})))))
    else $error("square accumulator past bound");
`endif

endmodule
